/* hdl/jse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared widths, character codes, request type and escape lookup functions.
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int CAP_WIDTH     = 16;
    localparam int LENGTH_WIDTH  = 16;
    localparam int COUNT_WIDTH_D = 16;
    localparam int SEQ_WIDTH     = 3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_NONE   = 8'h00;

    localparam logic [SEQ_WIDTH-1:0] LEN_PLAIN = 3'd1;
    localparam logic [SEQ_WIDTH-1:0] LEN_SHORT = 3'd2;
    localparam logic [SEQ_WIDTH-1:0] LEN_UNI   = 3'd6;

    typedef struct packed {
        logic [7:0]              raw;
        logic [SEQ_WIDTH-1:0]    num;
        logic                    cut;
        logic [LENGTH_WIDTH-1:0] base;
    } t_item;

    function automatic logic [7:0] esc_code(input logic [7:0] b);
        logic [7:0] c;
        case (b) inside
            CH_QUOTE, CH_BSLASH: c = b;
            CH_BS:               c = CH_B;
            CH_FF:               c = CH_F;
            CH_CR:               c = CH_R;
            CH_LF:               c = CH_N;
            CH_TAB:              c = CH_T;
            default:             c = CH_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [SEQ_WIDTH-1:0] esc_len(input logic [7:0] b);
        logic [SEQ_WIDTH-1:0] l;
        if (esc_code(b) != CH_NONE) begin
            l = LEN_SHORT;
        end else if (b < CH_SPACE) begin
            l = LEN_UNI;
        end else begin
            l = LEN_PLAIN;
        end
        return l;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = CH_ZERO + {4'd0, nib};
        end else begin
            d = CH_A + {4'd0, nib} - 8'd10;
        end
        return d;
    endfunction

    function automatic logic [7:0] esc_byte(input logic [7:0] b,
                                            input logic [SEQ_WIDTH-1:0] idx);
        logic [7:0] c;
        logic [7:0] o;
        c = esc_code(b);
        if (c != CH_NONE) begin
            o = (idx == 3'd0) ? CH_BSLASH : c;
        end else if (b < CH_SPACE) begin
            case (idx)
                3'd0:    o = CH_BSLASH;
                3'd1:    o = CH_U;
                3'd2:    o = CH_ZERO;
                3'd3:    o = CH_ZERO;
                3'd4:    o = hex_digit(b[7:4]);
                default: o = hex_digit(b[3:0]);
            endcase
        end else begin
            o = b;
        end
        return o;
    endfunction

endpackage

/* hdl/jse_emitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON escaper sequence emitter
// Holds one escape request and drains its bytes into the output register,
// one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module jse_emitter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  jse_pkg::t_item                 i_item,
    output logic                           o_free,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_run_last,
    output logic [jse_pkg::LENGTH_WIDTH-1:0] o_out_length,
    output logic                           o_truncated
);
    import jse_pkg::*;

    logic                    r_busy;
    t_item                   r_item;
    logic [SEQ_WIDTH-1:0]    r_idx;
    logic                    r_out_valid;
    logic [7:0]              r_out_byte;
    logic                    r_run_last;
    logic [LENGTH_WIDTH-1:0] r_out_length;
    logic                    r_truncated;

    logic adv;
    logic last;

    assign adv    = r_busy && (!r_out_valid || i_out_ready);
    assign last   = (r_idx == SEQ_WIDTH'(r_item.num - 3'd1));
    assign o_free = !r_busy || (adv && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid  <= 1'b1;
                r_out_byte   <= esc_byte(r_item.raw, r_idx);
                r_run_last   <= last;
                r_out_length <= r_item.base + LENGTH_WIDTH'(r_idx) + 16'd1;
                r_truncated  <= r_item.cut;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv && last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else if (adv) begin
                r_idx <= r_idx + 3'd1;
            end
            if (i_load) begin
                r_busy <= 1'b1;
                r_item <= i_item;
                r_idx  <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_last   = r_run_last;
    assign o_out_length = r_out_length;
    assign o_truncated  = r_truncated;

endmodule

/* hdl/json_string_escaper_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper
// Escapes one string byte per request and emits the escaped text a byte at a
// time, truncating each string at the configured output capacity.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_ready  | i_in_byte, i_end_of_string
//  out     | output    | o_out_valid / i_out_ready| o_out_byte, o_run_last,
//          |           |                          | o_out_length, o_truncated
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_data (out_capacity)
//
//  A plain byte can be taken every cycle while the output is not stalled;
//  its output byte passes through the emitter's request and output registers.
//  An escape keeps the input stalled until the emitter moves its last byte
//  into the output register. A dropped byte is taken and yields nothing.
//  Reset clears the string count and sets the capacity to 65535.
//  A stalled output holds its register; the emitter and input wait behind it.
// ----------------------------------------------------------------------------
module json_string_escaper_top #(
    parameter int COUNT_WIDTH = jse_pkg::COUNT_WIDTH_D
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_in_byte,
    input  logic                             i_end_of_string,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_out_byte,
    output logic                             o_run_last,
    output logic [jse_pkg::LENGTH_WIDTH-1:0] o_out_length,
    output logic                             o_truncated,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [jse_pkg::CAP_WIDTH-1:0]    i_cfg_data
);
    import jse_pkg::*;

    localparam int LW = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;

    logic [CAP_WIDTH-1:0]   r_capacity;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;

    logic [LW-1:0]        cap_ext;
    logic [LW-1:0]        cmax;
    logic [LW-1:0]        limit;
    logic [LW-1:0]        cnt_ext;
    logic [LW-1:0]        avail;
    logic [SEQ_WIDTH-1:0] seq_len;
    logic [SEQ_WIDTH-1:0] seq_num;
    logic                 accept;
    logic                 free;
    t_item                item;

    assign cap_ext = LW'(r_capacity);
    assign cmax    = LW'({COUNT_WIDTH{1'b1}});
    assign limit   = (cap_ext < cmax) ? cap_ext : cmax;
    assign cnt_ext = LW'(r_count);
    assign avail   = (limit > cnt_ext) ? (limit - cnt_ext) : '0;
    assign seq_len = esc_len(i_in_byte);
    assign seq_num = (avail < LW'(seq_len)) ? avail[SEQ_WIDTH-1:0] : seq_len;

    assign item.raw  = i_in_byte;
    assign item.num  = seq_num;
    assign item.cut  = (seq_num < seq_len);
    assign item.base = LENGTH_WIDTH'(r_count);

    assign o_in_ready  = free;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && free;
    assign n_count     = i_end_of_string ? '0 : r_count + COUNT_WIDTH'(seq_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= {CAP_WIDTH{1'b1}};
            r_count    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    jse_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept && (seq_num != '0)),
        .i_item       (item),
        .o_free       (free),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_out_length (o_out_length),
        .o_truncated  (o_truncated)
    );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper testbench
// Sends string bytes through the escaper, predicts each escaped output byte
// with its length count and cut flag, and checks every output request in
// order. Covers the escape table, capacity cuts, capacity changes between and
// within strings and random traffic with stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    import jse_pkg::*;

    localparam int COUNT_W = COUNT_WIDTH_D;

    typedef struct packed {
        logic [7:0]              ch;
        logic                    last;
        logic [LENGTH_WIDTH-1:0] len;
        logic                    cut;
    } t_esc_out;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_in_valid      = 1'b0;
    logic                    o_in_ready;
    logic [7:0]              i_in_byte       = 8'h00;
    logic                    i_end_of_string = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready     = 1'b0;
    logic [7:0]              o_out_byte;
    logic                    o_run_last;
    logic [LENGTH_WIDTH-1:0] o_out_length;
    logic                    o_truncated;
    logic                    i_cfg_valid     = 1'b0;
    logic                    o_cfg_ready;
    logic [CAP_WIDTH-1:0]    i_cfg_data      = '0;

    t_esc_out             escaped_q[$];
    logic [CAP_WIDTH-1:0] capacity   = '1;
    logic [COUNT_W-1:0]   string_len = '0;
    int                   errors     = 0;
    bit                   calm       = 1'b0;

    json_string_escaper_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_out_length    (o_out_length),
        .o_truncated     (o_truncated),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[json_string_escaper_top] ERROR");
        $finish;
    end

    // escaped text of one byte, cut at the capacity, queued as expected output
    task automatic escape_char(input logic [7:0] b, input logic eos);
        logic [7:0]      seq[6];
        int              nseq;
        int              n;
        longint unsigned lim;
        t_esc_out        e;
        nseq = 1;
        seq[0] = b;
        case (b) inside
            CH_QUOTE, CH_BSLASH: begin seq[0] = CH_BSLASH; seq[1] = b;    nseq = 2; end
            CH_BS:               begin seq[0] = CH_BSLASH; seq[1] = CH_B; nseq = 2; end
            CH_FF:               begin seq[0] = CH_BSLASH; seq[1] = CH_F; nseq = 2; end
            CH_CR:               begin seq[0] = CH_BSLASH; seq[1] = CH_R; nseq = 2; end
            CH_LF:               begin seq[0] = CH_BSLASH; seq[1] = CH_N; nseq = 2; end
            CH_TAB:              begin seq[0] = CH_BSLASH; seq[1] = CH_T; nseq = 2; end
            default: begin
                if (b < CH_SPACE) begin
                    seq[0] = CH_BSLASH;
                    seq[1] = CH_U;
                    seq[2] = CH_ZERO;
                    seq[3] = CH_ZERO;
                    seq[4] = CH_ZERO + {4'd0, b[7:4]};
                    seq[5] = (b[3:0] < 4'd10) ? CH_ZERO + {4'd0, b[3:0]}
                                              : CH_A + {4'd0, b[3:0]} - 8'd10;
                    nseq = 6;
                end
            end
        endcase
        lim = capacity;
        if (lim > (64'd1 << COUNT_W) - 1) begin
            lim = (64'd1 << COUNT_W) - 1;
        end
        n = 0;
        while (n < nseq && string_len < lim) begin
            string_len++;
            e.ch   = seq[n];
            e.last = 1'b0;
            e.len  = LENGTH_WIDTH'(string_len);
            e.cut  = 1'b0;
            escaped_q.push_back(e);
            n++;
        end
        for (int k = 0; k < n; k++) begin
            escaped_q[escaped_q.size() - n + k].cut = (n < nseq);
        end
        if (n > 0) begin
            escaped_q[escaped_q.size() - 1].last = 1'b1;
        end
        if (eos) begin
            string_len = '0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_esc_out want;
        if (!i_rst_n) begin
            capacity   = '1;
            string_len = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                capacity = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                escape_char(i_in_byte, i_end_of_string);
            end
            if (o_out_valid && i_out_ready) begin
                if (escaped_q.size() == 0) begin
                    $error("unexpected output byte %h", o_out_byte);
                    errors++;
                end else begin
                    want = escaped_q.pop_front();
                    if (o_out_byte !== want.ch) begin
                        $error("out_byte: expected %h, got %h", want.ch, o_out_byte);
                        errors++;
                    end
                    if (o_run_last !== want.last) begin
                        $error("run_last: expected %b, got %b", want.last, o_run_last);
                        errors++;
                    end
                    if (o_out_length !== want.len) begin
                        $error("out_length: expected %0d, got %0d", want.len, o_out_length);
                        errors++;
                    end
                    if (o_truncated !== want.cut) begin
                        $error("truncated: expected %b, got %b", want.cut, o_truncated);
                        errors++;
                    end
                end
            end
        end
    end

    // output stalls in bursts
    initial begin : out_pacing
        int n;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 12);
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_char(input logic [7:0] b, input logic eos);
        int gap;
        i_in_valid      <= 1'b1;
        i_in_byte       <= b;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (!o_in_ready);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one edge first so the last accepted request is already queued
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (escaped_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_WIDTH-1:0] cap);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] specials[9] = '{CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_CR,
                                    CH_LF, CH_TAB, 8'h00, 8'h1f};
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0, 1:    c = 8'($urandom_range(8'h20, 8'h7e));
            2:       c = specials[$urandom_range(0, 8)];
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    task automatic send_string(input int len);
        for (int i = 0; i < len; i++) begin
            send_char(pick_char(), i == len - 1);
        end
    endtask

    task automatic test_escape_table();
        logic [7:0] chars[16] = '{8'h00, 8'h1f, 8'h1a, CH_BS, CH_FF, CH_CR, CH_LF, CH_TAB,
                                  CH_QUOTE, CH_BSLASH, CH_SPACE, 8'h41, 8'h7f, 8'h80,
                                  8'hff, 8'h01};
        write_capacity(16'hffff);
        for (int i = 0; i < 16; i++) begin
            send_char(chars[i], i == 7 || i == 15);
        end
    endtask

    task automatic test_capacity_cut();
        write_capacity(16'd5);
        send_char(8'h01, 1'b0);      // unicode escape cut to five
        send_char(8'h61, 1'b1);      // dropped, still ends the string
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(8'h02, 1'b1);      // one byte left
        write_capacity(16'd0);
        send_char(8'h41, 1'b0);
        send_char(CH_QUOTE, 1'b1);
        write_capacity(16'd1);
        send_char(CH_TAB, 1'b0);
        send_char(8'h42, 1'b1);
        send_char(8'h43, 1'b1);
    endtask

    task automatic test_capacity_lowered();
        write_capacity(16'd10);
        for (int i = 0; i < 6; i++) begin
            send_char(8'h61 + 8'(i), 1'b0);
        end
        write_capacity(16'd3);
        send_char(8'h67, 1'b0);
        send_char(8'h68, 1'b1);
        send_char(8'h69, 1'b1);
    endtask

    task automatic test_random_traffic(input int target);
        int sent;
        int len;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 3) == 0) begin
                write_capacity($urandom_range(0, 1) ? 16'hffff
                                                    : CAP_WIDTH'($urandom_range(1, 40)));
            end
            len = $urandom_range(1, 16);
            send_string(len);
            sent += len;
        end
    endtask

    task automatic test_back_to_back(input int target);
        int sent;
        int len;
        wait_idle();
        calm = 1'b1;
        write_capacity(CAP_WIDTH'($urandom_range(6, 30)));
        sent = 0;
        while (sent < target) begin
            len = $urandom_range(1, 12);
            send_string(len);
            sent += len;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_escape_table();
        test_capacity_cut();
        test_capacity_lowered();
        test_random_traffic(240);
        test_back_to_back(60);
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("[json_string_escaper_top] OK");
        end else begin
            $display("[json_string_escaper_top] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/jse_pkg.sv
hdl/jse_emitter.sv
hdl/json_string_escaper_top.sv
bench/tb_top.sv
